// ===== design/pfd_pkg.sv =====
package pfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 10;
    localparam int MAX_FRAME  = 512;
    localparam int MAX_CMP_W  = $clog2(MAX_FRAME + 1);
    localparam int CMP_W      = (CNT_W > MAX_CMP_W) ? CNT_W : MAX_CMP_W;

    localparam logic [BYTE_W-1:0] DECODE_LIMIT  = 8'h30;
    localparam logic [BYTE_W-1:0] DECODE_OFFSET = 8'h40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_LEAD_BYTE = 1'b0;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_CSUM_ERR = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [CNT_W-1:0]  frame_length;
    } t_result;

endpackage

// ===== design/pfd_core.sv =====
module pfd_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [pfd_pkg::BYTE_W-1:0] i_in_byte,
    output logic                       o_in_ready,
    input  logic [pfd_pkg::BYTE_W-1:0] i_lead_byte,
    input  logic                       i_res_space,
    output logic                       o_res_valid,
    output pfd_pkg::t_result           o_res
);
    import pfd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_frame;
    logic [BYTE_W-1:0] r_bytes_left;
    logic [BYTE_W-1:0] r_sum;
    logic [CNT_W-1:0]  r_count;

    logic              n_in_frame;
    logic [BYTE_W-1:0] n_bytes_left;
    logic [BYTE_W-1:0] n_sum;
    logic [CNT_W-1:0]  n_count;

    logic              advance;
    logic              emit;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] decoded;
    logic              at_limit;

    assign advance    = r_in_valid && i_res_space;
    assign o_in_ready = !r_in_valid || advance;

    assign left_dec = r_bytes_left - 1'b1;
    assign sum_add  = r_sum + r_in_byte;
    assign decoded  = (r_in_byte < DECODE_LIMIT) ? (r_in_byte + DECODE_OFFSET) : r_in_byte;
    assign at_limit = CMP_W'(r_count) >= CMP_W'(MAX_FRAME);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_count      = r_count;
        emit         = 1'b0;
        o_res        = '{kind: KIND_PAYLOAD, payload_byte: '0, frame_length: r_count};
        if (!r_in_frame) begin
            if (r_in_byte == i_lead_byte) begin
                n_in_frame   = 1'b1;
                n_bytes_left = '0;
                n_sum        = '0;
                n_count      = '0;
            end
        end else if (r_bytes_left == '0) begin
            n_bytes_left = r_in_byte;
            n_sum        = r_in_byte;
        end else if (left_dec != '0) begin
            if (at_limit) begin
                n_in_frame   = 1'b0;
                n_bytes_left = '0;
                n_sum        = '0;
                n_count      = '0;
                emit         = 1'b1;
                o_res.kind   = KIND_OVERFLOW;
            end else begin
                n_bytes_left       = left_dec;
                n_sum              = sum_add;
                n_count            = r_count + 1'b1;
                emit               = 1'b1;
                o_res.payload_byte = decoded;
                o_res.frame_length = r_count + 1'b1;
            end
        end else begin
            n_in_frame   = 1'b0;
            n_bytes_left = '0;
            n_sum        = '0;
            n_count      = '0;
            if (sum_add == '0) begin
                emit       = (r_count != '0);
                o_res.kind = KIND_GOOD;
            end else begin
                emit       = 1'b1;
                o_res.kind = KIND_CSUM_ERR;
            end
        end
    end

    assign o_res_valid = advance && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_count      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_in_frame   <= n_in_frame;
                r_bytes_left <= n_bytes_left;
                r_sum        <= n_sum;
                r_count      <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

endmodule

// ===== design/pfd_out_queue.sv =====
module pfd_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pfd_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output pfd_pkg::t_result o_data
);
    import pfd_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/packet_frame_deframer.sv =====
// A result passes the input register and the result queue before it is offered.
// Throughput: one item per cycle while the result queue has space; the input
// register feeds the per-byte update, and a two-entry result queue lets input
// continue while a result waits. Reset (synchronous, active low) returns to
// hunting, clears the frame state and the queue, and sets lead_byte to zero.
module packet_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pfd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_out_kind,
    output logic [pfd_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [pfd_pkg::CNT_W-1:0]      o_frame_length,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import pfd_pkg::*;

    logic [BYTE_W-1:0] r_lead_byte;
    logic              res_valid;
    logic              res_space;
    t_result           res;
    t_result           out_data;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1];
    assign prdata  = (reg_sel == REG_LEAD_BYTE) ? APB_DATA_W'(r_lead_byte) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_byte <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_LEAD_BYTE) begin
            r_lead_byte <= pwdata[BYTE_W-1:0];
        end
    end

    pfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_byte   (i_rx_byte),
        .o_in_ready  (o_ready),
        .i_lead_byte (r_lead_byte),
        .i_res_space (res_space),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pfd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (res_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_out_kind     = out_data.kind;
    assign o_payload_byte = out_data.payload_byte;
    assign o_frame_length = out_data.frame_length;

endmodule

// ===== dv/tb_packet_frame_deframer.sv =====
`timescale 1ns / 100ps

module tb_packet_frame_deframer;
    import pfd_pkg::*;

    localparam logic [APB_ADDR_W-1:0] LEAD_ADDR   = APB_ADDR_W'(4 * int'(REG_LEAD_BYTE));
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4);
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 6;

    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_CUT} t_frame_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [BYTE_W-1:0]     i_rx_byte = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_out_kind;
    logic [BYTE_W-1:0]     o_payload_byte;
    logic [CNT_W-1:0]      o_frame_length;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    packet_frame_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_kind     (o_out_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_length (o_frame_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [BYTE_W-1:0] rx_stream_q [$];
    t_result           deframed_q [$];
    int                mismatch_cnt = 0;

    logic [BYTE_W-1:0] lead_cfg = '0;
    logic              fr_open = 1'b0;
    logic [BYTE_W-1:0] fr_left = '0;
    logic [BYTE_W-1:0] fr_sum = '0;
    logic [CNT_W-1:0]  fr_count = '0;

    logic [BYTE_W-1:0] dir_items [$] = '{
        8'h55, 8'h00, 8'h00, 8'h03, 8'h00, 8'hFF, 8'hFE,
        8'h00, 8'h01, 8'hFF,
        8'h00, 8'h01, 8'h00,
        8'h00, 8'h04, 8'h2F, 8'h30, 8'h12, 8'h77,
        8'h00, 8'h02, 8'h00, 8'hFE,
        8'hAA
    };

    function automatic void restart_hunt();
        fr_open  = 1'b0;
        fr_left  = '0;
        fr_sum   = '0;
        fr_count = '0;
    endfunction

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] raw, output t_result res);
        logic [BYTE_W-1:0] dec;
        logic [CNT_W-1:0]  len;
        res = '0;
        if (!fr_open) begin
            if (raw == lead_cfg) begin
                restart_hunt();
                fr_open = 1'b1;
            end
            return 1'b0;
        end
        if (fr_left == 0) begin
            fr_left = raw;
            fr_sum  = raw;
            return 1'b0;
        end
        fr_left = fr_left - 1'b1;
        fr_sum  = fr_sum + raw;
        dec = (raw < DECODE_LIMIT) ? raw + DECODE_OFFSET : raw;
        if (fr_left != 0) begin
            if (fr_count >= MAX_FRAME) begin
                res.kind = KIND_OVERFLOW;
                res.frame_length = fr_count;
                restart_hunt();
                return 1'b1;
            end
            fr_count = fr_count + 1'b1;
            res.kind = KIND_PAYLOAD;
            res.payload_byte = dec;
            res.frame_length = fr_count;
            return 1'b1;
        end
        len = fr_count;
        if (fr_sum == 0) begin
            restart_hunt();
            if (len == 0) begin
                return 1'b0;
            end
            res.kind = KIND_GOOD;
            res.frame_length = len;
            return 1'b1;
        end
        restart_hunt();
        res.kind = KIND_CSUM_ERR;
        res.frame_length = len;
        return 1'b1;
    endfunction

    // sender
    int      burst_left = 0;
    int      gap_left = 0;
    bit      tx_gapless = 1'b0;
    logic    tx_valid_nxt;
    t_result pred_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (deframe_byte(i_rx_byte, pred_res)) begin
                    deframed_q.push_back(pred_res);
                end
            end
            if (!i_valid || o_ready) begin
                tx_valid_nxt = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (rx_stream_q.size() > 0) begin
                    tx_valid_nxt = 1'b1;
                    i_rx_byte <= rx_stream_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (tx_gapless || $urandom_range(0, 3) == 0) ? 0 :
                                   $urandom_range(1, 8);
                    end
                end
                i_valid <= tx_valid_nxt;
            end
        end
    end

    // receiver
    int      rx_hold_reqs = 0;
    int      rx_hold_served = 0;
    int      rx_hold_left = 0;
    int      rx_tick = 0;
    int      rx_mode = 0;
    logic    rx_ready_nxt;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (deframed_q.size() == 0) begin
                    $error("unexpected result: out_kind %0d payload_byte %0h frame_length %0d",
                           o_out_kind, o_payload_byte, o_frame_length);
                    mismatch_cnt++;
                end else begin
                    want = deframed_q.pop_front();
                    if (o_out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, o_out_kind);
                        mismatch_cnt++;
                    end
                    if (o_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want.payload_byte, o_payload_byte);
                        mismatch_cnt++;
                    end
                    if (o_frame_length !== want.frame_length) begin
                        $error("frame_length: expected %0d, actual %0d",
                               want.frame_length, o_frame_length);
                        mismatch_cnt++;
                    end
                end
            end
            if (rx_hold_reqs != rx_hold_served) begin
                rx_hold_served++;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rx_ready_nxt = 1'b0;
            end else begin
                rx_tick++;
                if (rx_tick % 64 == 0) begin
                    rx_mode = $urandom_range(0, 2);
                end
                case (rx_mode)
                    0: rx_ready_nxt = 1'b1;
                    1: rx_ready_nxt = 1'($urandom_range(0, 1));
                    default: rx_ready_nxt = (rx_tick % 3 == 0);
                endcase
            end
            i_ready <= rx_ready_nxt;
        end
    end

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == LEAD_ADDR) begin
            lead_cfg = data[BYTE_W-1:0];
        end
    endtask

    task automatic queue_frame(input t_frame_shape shape);
        logic [BYTE_W-1:0] cnt;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int n_body;
        rx_stream_q.push_back(lead_cfg);
        if ($urandom_range(0, 7) == 0) begin
            rx_stream_q.push_back(8'h00);
        end
        cnt = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) :
                                             8'($urandom_range(1, 12));
        rx_stream_q.push_back(cnt);
        sum = cnt;
        n_body = (shape == FRAME_CUT) ? $urandom_range(0, cnt - 1) : cnt - 1;
        repeat (n_body) begin
            b = 8'($urandom());
            rx_stream_q.push_back(b);
            sum = sum + b;
        end
        if (shape == FRAME_GOOD) begin
            rx_stream_q.push_back(8'(8'h00 - sum));
        end else if (shape == FRAME_BAD_SUM) begin
            rx_stream_q.push_back(8'(8'h00 - sum + 8'($urandom_range(1, 255))));
        end
    endtask

    task automatic queue_random(input int n_items);
        int added;
        int prior;
        int pick;
        added = 0;
        while (added < n_items) begin
            prior = rx_stream_q.size();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4)) rx_stream_q.push_back(8'($urandom()));
            end else if (pick == 1) begin
                queue_frame(FRAME_CUT);
            end else if (pick == 2) begin
                queue_frame(FRAME_BAD_SUM);
            end else begin
                queue_frame(FRAME_GOOD);
            end
            added += rx_stream_q.size() - prior;
        end
    endtask

    task automatic wait_drained();
        while (rx_stream_q.size() != 0 || i_valid || deframed_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_items[k]) rx_stream_q.push_back(dir_items[k]);
        queue_random(200);
        wait_drained();

        write_reg(LEAD_ADDR, {24'($urandom()), 8'hFF});
        tx_gapless = 1'b1;
        queue_random(250);
        wait_drained();
        tx_gapless = 1'b0;

        write_reg(UNUSED_ADDR, $urandom());
        write_reg(LEAD_ADDR, {24'($urandom()), 8'h7E});
        queue_random(250);
        rx_hold_reqs++;
        wait_drained();

        write_reg(LEAD_ADDR, {24'($urandom()), 8'($urandom_range(1, 254))});
        queue_random(250);
        rx_hold_reqs++;
        wait_drained();

        write_reg(LEAD_ADDR, {24'($urandom()), 8'h00});
        queue_random(150);
        wait_drained();

        if (mismatch_cnt == 0 && deframed_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/pfd_pkg.sv
design/pfd_core.sv
design/pfd_out_queue.sv
design/packet_frame_deframer.sv
dv/tb_packet_frame_deframer.sv
